[rtl/sma_pkg.sv]
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants for the slot allocator: slot count, index
// widths, function codes and the structs that pass between the modules.
// ----------------------------------------------------------------------------
package sma_pkg;

   // table geometry
   localparam int SLOTS       = 32;
   localparam int IDX_W       = $clog2(SLOTS);
   localparam int LIFE_W      = 12;
   localparam int SLOT_FIELD_W = 5;

   // starting best life for the eviction search; any slot with lower life beats it
   localparam logic [LIFE_W-1:0] LIFE_MAX = {LIFE_W{1'b1}};

   // request function codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // one table entry as held in the slot memory
   typedef struct packed {
      logic              active;
      logic [LIFE_W-1:0] life;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // memory access from the controller
   typedef struct packed {
      logic [IDX_W-1:0] raddr;
      logic             wen;
      logic [IDX_W-1:0] waddr;
      slot_entry_type   wdata;
   } ram_cmd_type;

   // one finished result
   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] chosen_slot;
      logic                    evicted;
   } result_type;

endpackage

[rtl/sma_ram.sv]
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/sma_ctrl.sv]
// ----------------------------------------------------------------------------
// sma_ctrl
// Request sequencer: applies slot writes, runs the circular allocation scan
// one slot per cycle over the slot memory, claims the chosen slot and hands
// the result to the output stage.
// ----------------------------------------------------------------------------
module sma_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [sma_pkg::SLOT_FIELD_W-1:0]    req_slot_index,
   input  logic                                req_in_use,
   input  logic [sma_pkg::LIFE_W-1:0]          req_life,
   output sma_pkg::ram_cmd_type                ram_cmd,
   input  sma_pkg::slot_entry_type             ram_rdata,
   output logic                                res_valid,
   output sma_pkg::result_type                 res,
   input  logic                                res_take
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [sma_pkg::IDX_W-1:0] LAST_IDX = sma_pkg::IDX_W'(sma_pkg::SLOTS - 1);

   logic [1:0]                    state_ff, state_in;
   logic [sma_pkg::SLOTS-1:0]     valid_ff, valid_in;
   logic [sma_pkg::IDX_W-1:0]     start_ff, start_in;
   logic [sma_pkg::IDX_W-1:0]     chk_addr_ff, chk_addr_in;
   logic [sma_pkg::IDX_W-1:0]     nxt_addr_ff, nxt_addr_in;
   logic [sma_pkg::IDX_W-1:0]     chk_cnt_ff, chk_cnt_in;
   logic                          vbit_ff, vbit_in;
   logic [sma_pkg::IDX_W-1:0]     best_ff, best_in;
   logic [sma_pkg::LIFE_W-1:0]    best_life_ff, best_life_in;
   logic [sma_pkg::LIFE_W-1:0]    life_ff, life_in;
   sma_pkg::result_type           res_ff, res_in;

   logic                          accept;
   logic                          idx_in_range;
   logic [sma_pkg::IDX_W-1:0]     wr_idx;
   logic                          cur_active;
   logic [sma_pkg::LIFE_W-1:0]    cur_life;
   logic                          better;
   logic [sma_pkg::IDX_W-1:0]     best_now;
   logic [sma_pkg::IDX_W-1:0]     pick;

   function automatic logic [sma_pkg::IDX_W-1:0] next_slot(
      input logic [sma_pkg::IDX_W-1:0] s
   );
      logic [sma_pkg::IDX_W-1:0] n;
      n = (s == LAST_IDX) ? '0 : s + 1'b1;
      return n;
   endfunction

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign idx_in_range = (32'(req_slot_index) < sma_pkg::SLOTS);
   assign wr_idx       = sma_pkg::IDX_W'(req_slot_index);

   // slot under examination; an entry never written reads as free with zero life
   assign cur_active = vbit_ff && ram_rdata.active;
   assign cur_life   = vbit_ff ? ram_rdata.life : '0;
   assign better     = (cur_life < best_life_ff);
   assign best_now   = better ? chk_addr_ff : best_ff;
   assign pick       = !cur_active ? chk_addr_ff : best_now;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      start_in     = start_ff;
      chk_addr_in  = chk_addr_ff;
      nxt_addr_in  = nxt_addr_ff;
      chk_cnt_in   = chk_cnt_ff;
      vbit_in      = vbit_ff;
      best_in      = best_ff;
      best_life_in = best_life_ff;
      life_in      = life_ff;
      res_in       = res_ff;
      ram_cmd      = '0;
      ram_cmd.raddr = start_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               life_in = req_life;
               if (req_func == sma_pkg::FUNC_WRITE) begin
                  if (idx_in_range) begin
                     ram_cmd.wen          = 1'b1;
                     ram_cmd.waddr        = wr_idx;
                     ram_cmd.wdata.active = req_in_use;
                     ram_cmd.wdata.life   = req_life;
                     valid_in[wr_idx]     = 1'b1;
                  end
                  res_in.chosen_slot = req_slot_index;
                  res_in.evicted     = 1'b0;
                  state_in           = ST_DONE;
               end else begin
                  // first read goes out now at the start pointer
                  ram_cmd.raddr = start_ff;
                  vbit_in       = valid_ff[start_ff];
                  chk_addr_in   = start_ff;
                  nxt_addr_in   = next_slot(start_ff);
                  chk_cnt_in    = '0;
                  best_in       = '0;
                  best_life_in  = sma_pkg::LIFE_MAX;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read ahead the next slot while checking the current one
            ram_cmd.raddr = nxt_addr_ff;
            vbit_in       = valid_ff[nxt_addr_ff];
            chk_addr_in   = nxt_addr_ff;
            nxt_addr_in   = next_slot(nxt_addr_ff);
            best_in       = best_now;
            best_life_in  = better ? cur_life : best_life_ff;
            chk_cnt_in    = chk_cnt_ff + 1'b1;
            if (!cur_active || (chk_cnt_ff == LAST_IDX)) begin
               // claim the chosen slot
               ram_cmd.wen          = 1'b1;
               ram_cmd.waddr        = pick;
               ram_cmd.wdata.active = 1'b1;
               ram_cmd.wdata.life   = life_ff;
               valid_in[pick]       = 1'b1;
               start_in             = next_slot(pick);
               res_in.chosen_slot   = sma_pkg::SLOT_FIELD_W'(pick);
               res_in.evicted       = cur_active;
               state_in             = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         start_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         start_ff <= start_in;
      end
   end

   // scan and payload registers
   always_ff @(posedge clock) begin
      chk_addr_ff  <= chk_addr_in;
      nxt_addr_ff  <= nxt_addr_in;
      chk_cnt_ff   <= chk_cnt_in;
      vbit_ff      <= vbit_in;
      best_ff      <= best_in;
      best_life_ff <= best_life_in;
      life_ff      <= life_in;
      res_ff       <= res_in;
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

[rtl/slot_allocator_min_life_evict_top.sv]
// ----------------------------------------------------------------------------
// slot_allocator_min_life_evict_top
// Round-robin free slot allocator with minimum-life eviction over a table
// of slots held in a synchronous memory.
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, func, slot_index, in_use, life
//   rsp      out        rsp_valid/rsp_ready, chosen_slot, evicted
//
// A write beat goes from accept straight to the result. An allocate beat scans
// until it finds a free slot or has checked every slot: the scan reads one
// slot per cycle through the single read port of the slot memory.
// Reset clears the per-slot valid bits at once, so no clearing pass runs.
// A result waits in the output register while the next beat is accepted;
// the sequencer stalls only if it finishes while that register is still full.
// ----------------------------------------------------------------------------
module slot_allocator_min_life_evict_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [sma_pkg::SLOT_FIELD_W-1:0]   req_slot_index,
   input  logic                               req_in_use,
   input  logic [sma_pkg::LIFE_W-1:0]         req_life,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sma_pkg::SLOT_FIELD_W-1:0]   rsp_chosen_slot,
   output logic                               rsp_evicted
);

   sma_pkg::ram_cmd_type     ram_cmd;
   sma_pkg::slot_entry_type  ram_rdata;
   logic [sma_pkg::ENTRY_W-1:0] ram_rdata_raw;
   logic                     res_valid;
   sma_pkg::result_type      res;
   logic                     res_take;
   logic                     rsp_valid_ff, rsp_valid_in;
   sma_pkg::result_type      rsp_ff, rsp_in;

   // slot table
   sma_ram #(
      .WIDTH (sma_pkg::ENTRY_W),
      .DEPTH (sma_pkg::SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .wen   (ram_cmd.wen),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = sma_pkg::slot_entry_type'(ram_rdata_raw);

   // request sequencer
   sma_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_slot_index (req_slot_index),
      .req_in_use     (req_in_use),
      .req_life       (req_life),
      .ram_cmd        (ram_cmd),
      .ram_rdata      (ram_rdata),
      .res_valid      (res_valid),
      .res            (res),
      .res_take       (res_take)
   );

   // output register
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_slot = rsp_ff.chosen_slot;
   assign rsp_evicted     = rsp_ff.evicted;

endmodule
